// ===== design/best_basis_pair_search_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef BEST_BASIS_PAIR_SEARCH_CORE_ASSERT_SVH
`define BEST_BASIS_PAIR_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, muted while reset is asserted.
`define BBPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bbps check failed");

// Next-cycle implication, muted while reset is asserted.
`define BBPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bbps check failed");

`endif

// ===== design/bbps_pkg.sv =====
`default_nettype none

package bbps_pkg;

  // Defaults for the top-level parameters
  localparam int BASIS_DEPTH_DEF = 256;
  localparam int VALUE_BITS_DEF  = 32;

  // Fixed field widths
  localparam int CMD_BITS   = 1;
  localparam int IDX_BITS   = 8;
  localparam int OPV_BITS   = 32;
  localparam int CODE_BITS  = 9;
  localparam int LEN_BITS   = 9;
  localparam int OFS_BITS   = 8;
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;
  localparam int LG_IN_BITS = 16;
  localparam int LG_BITS    = 5;
  localparam int SCORE_BITS = LG_BITS + 1;

  // Command codes
  localparam logic [CMD_BITS-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_BITS-1:0] CMD_QUERY = 1'b1;

  // Register indexes (paddr[2])
  localparam logic REG_LENGTH = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  typedef struct packed {
    logic [LEN_BITS-1:0] basis_length;
    logic [OFS_BITS-1:0] index_offset;
  } cfg_t;

  typedef struct packed {
    logic                 pair_found;
    logic [CODE_BITS-1:0] first_code;
    logic [CODE_BITS-1:0] second_code;
  } res_t;

  // floor(log2(n+1)); the gamma length is 2*this+1, so scores compare on the sum
  function automatic logic [LG_BITS-1:0] lg_of_inc(input logic [LG_IN_BITS-1:0] n);
    logic [LG_IN_BITS:0] v;
    logic [LG_BITS-1:0]  r;
    v = {1'b0, n} + (LG_IN_BITS+1)'(1);
    r = '0;
    for (int b = 1; b <= LG_IN_BITS; b++) begin
      if (v[b]) r = LG_BITS'(b);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/bbps_in_if.sv =====
`default_nettype none

interface bbps_in_if;
  import bbps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CMD_BITS-1:0]  command;
  logic [IDX_BITS-1:0]  entry_index;
  logic [OPV_BITS-1:0]  operand_value;

  modport source (output valid, output command, output entry_index,
                  output operand_value, input ready);
  modport sink   (input valid, input command, input entry_index,
                  input operand_value, output ready);
endinterface

`default_nettype wire

// ===== design/bbps_res_if.sv =====
`default_nettype none

interface bbps_res_if;
  import bbps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 pair_found;
  logic [CODE_BITS-1:0] first_code;
  logic [CODE_BITS-1:0] second_code;

  modport source (output valid, output pair_found, output first_code,
                  output second_code, input ready);
  modport sink   (input valid, input pair_found, input first_code,
                  input second_code, output ready);
endinterface

`default_nettype wire

// ===== design/bbps_ram.sv =====
`default_nettype none

// One write port, two read ports, registered read data
module bbps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== design/bbps_cfg.sv =====
`default_nettype none

module bbps_cfg import bbps_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_BITS-1:0] paddr,
  input  wire logic [PDATA_BITS-1:0] pwdata,
  output logic      [PDATA_BITS-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  logic [LEN_BITS-1:0] len_q;
  logic [OFS_BITS-1:0] ofs_q;
  logic                wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_BITS'(1);
      ofs_q <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_LENGTH: len_q <= pwdata[LEN_BITS-1:0];
        REG_OFFSET: ofs_q <= pwdata[OFS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      REG_LENGTH: prdata = PDATA_BITS'(len_q);
      REG_OFFSET: prdata = PDATA_BITS'(ofs_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.basis_length = len_q;
  assign cfg_o.index_offset = ofs_q;

endmodule

`default_nettype wire

// ===== design/bbps_walk.sv =====
`default_nettype none

// Query sequencer: bound scan, then two-pointer walk over the table
module bbps_walk import bbps_pkg::*; #(
  parameter int BASIS_DEPTH = BASIS_DEPTH_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire cfg_t                           cfg_i,
  input  wire logic                           start_i,
  input  wire logic [VALUE_BITS-1:0]          val_i,
  input  wire logic                           take_i,
  output logic                                busy_o,
  output logic                                done_o,
  output res_t                                res_o,
  output logic      [$clog2(BASIS_DEPTH)-1:0] raddr_a_o,
  output logic      [$clog2(BASIS_DEPTH)-1:0] raddr_b_o,
  input  wire logic [VALUE_BITS-1:0]          rdata_a_i,
  input  wire logic [VALUE_BITS-1:0]          rdata_b_i
);

  localparam int AW = $clog2(BASIS_DEPTH);
  localparam int CW = $clog2(BASIS_DEPTH + 1);
  localparam int PW = $clog2(BASIS_DEPTH + 256);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BOUND  = 3'd1;
  localparam logic [2:0] S_WSTART = 3'd2;
  localparam logic [2:0] S_WLOAD  = 3'd3;
  localparam logic [2:0] S_WALK   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]            state_q, state_d;
  logic                  pend_q, pend_d;
  logic [CW-1:0]         k_q, k_d;
  logic [CW-1:0]         len_q, len_d;
  logic [AW-1:0]         maxb_q, maxb_d;
  logic [AW-1:0]         i_q, i_d;
  logic [AW-1:0]         j_q, j_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [VALUE_BITS-1:0] a_q, a_d;
  logic [VALUE_BITS-1:0] b_q, b_d;
  logic                  found_q, found_d;
  logic [SCORE_BITS-1:0] best_q, best_d;
  logic [CODE_BITS-1:0]  code1_q, code1_d;
  logic [CODE_BITS-1:0]  code2_q, code2_d;

  logic [CW-1:0]         eff_len;
  logic [VALUE_BITS:0]   pair_sum;
  logic                  sum_above;
  logic                  sum_equal;
  logic [PW-1:0]         p1, p2;
  logic [SCORE_BITS-1:0] score;
  logic                  hit;

  // Length clamped into 1..BASIS_DEPTH
  always_comb begin
    if (cfg_i.basis_length == '0) begin
      eff_len = CW'(1);
    end else if (32'(cfg_i.basis_length) > BASIS_DEPTH) begin
      eff_len = CW'(BASIS_DEPTH);
    end else begin
      eff_len = CW'(cfg_i.basis_length);
    end
  end

  // Pair sum one bit wider than the data, and gamma score of the pair
  assign pair_sum  = {1'b0, a_q} + {1'b0, b_q};
  assign sum_above = pair_sum > {1'b0, val_q};
  assign sum_equal = pair_sum == {1'b0, val_q};
  assign p1        = PW'(i_q) + PW'(cfg_i.index_offset);
  assign p2        = PW'(j_q - i_q) + PW'(cfg_i.index_offset);
  assign score     = SCORE_BITS'(lg_of_inc(LG_IN_BITS'(p1)))
                   + SCORE_BITS'(lg_of_inc(LG_IN_BITS'(p2)));
  assign hit       = pend_q && (rdata_a_i < val_q);

  // Next-state logic
  always_comb begin
    state_d   = state_q;
    pend_d    = pend_q;
    k_d       = k_q;
    len_d     = len_q;
    maxb_d    = maxb_q;
    i_d       = i_q;
    j_d       = j_q;
    val_d     = val_q;
    a_d       = a_q;
    b_d       = b_q;
    found_d   = found_q;
    best_d    = best_q;
    code1_d   = code1_q;
    code2_d   = code2_q;
    raddr_a_o = '0;
    raddr_b_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          val_d   = val_i;
          len_d   = eff_len;
          k_d     = CW'(1);
          pend_d  = 1'b0;
          maxb_d  = '0;
          found_d = 1'b0;
          best_d  = '0;
          code1_d = '0;
          code2_d = '0;
          state_d = S_BOUND;
        end
      end
      // Streamed scan: data for entry maxb+1 returns in the cycle after issue
      S_BOUND: begin
        if (pend_q && !hit) begin
          pend_d  = 1'b0;
          state_d = S_WSTART;
        end else begin
          if (hit) maxb_d = maxb_q + AW'(1);
          if (k_q < len_q) begin
            raddr_a_o = AW'(k_q);
            k_d       = k_q + CW'(1);
            pend_d    = 1'b1;
          end else begin
            pend_d = 1'b0;
            if (!pend_q) state_d = S_WSTART;
          end
        end
      end
      S_WSTART: begin
        raddr_a_o = '0;
        raddr_b_o = maxb_q;
        i_d       = '0;
        j_d       = maxb_q;
        state_d   = S_WLOAD;
      end
      // Prime both ends, then prefetch the neighbors i+1 and j-1
      S_WLOAD: begin
        a_d       = rdata_a_i;
        b_d       = rdata_b_i;
        raddr_a_o = i_q + AW'(1);
        raddr_b_o = j_q - AW'(1);
        state_d   = S_WALK;
      end
      S_WALK: begin
        if (sum_equal && (!found_q || score < best_q)) begin
          found_d = 1'b1;
          best_d  = score;
          code1_d = CODE_BITS'(p1);
          code2_d = CODE_BITS'(p2);
        end
        if (sum_above) begin
          j_d = j_q - AW'(1);
          b_d = rdata_b_i;
        end else begin
          i_d = i_q + AW'(1);
          a_d = rdata_a_i;
        end
        raddr_a_o = i_d + AW'(1);
        raddr_b_o = j_d - AW'(1);
        if (i_q == j_q) state_d = S_DONE;
      end
      S_DONE: begin
        if (take_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    len_q   <= len_d;
    maxb_q  <= maxb_d;
    i_q     <= i_d;
    j_q     <= j_d;
    val_q   <= val_d;
    a_q     <= a_d;
    b_q     <= b_d;
    found_q <= found_d;
    best_q  <= best_d;
    code1_q <= code1_d;
    code2_q <= code2_d;
  end

  assign busy_o            = state_q != S_IDLE;
  assign done_o            = state_q == S_DONE;
  assign res_o.pair_found  = found_q;
  assign res_o.first_code  = code1_q;
  assign res_o.second_code = code2_q;

endmodule

`default_nettype wire

// ===== design/best_basis_pair_search_core.sv =====
// Load item: written to the table at the accepting edge, no result; one per cycle
// while no query runs. Query item: a bound scan finds the upper index M, then a
// two-pointer pair walk runs over 0..M and the result is registered at the output.
// The input stays closed until then, and longer while an earlier result stalls.
// The bound scan reads the table once per cycle through port a, the walk through both.
// Reset clears control and sets the registers (length 1, offset 0); table is not cleared.
`default_nettype none

module best_basis_pair_search_core import bbps_pkg::*; #(
  parameter int BASIS_DEPTH = BASIS_DEPTH_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  bbps_in_if.sink                    item_in_i,
  bbps_res_if.source                 result_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_BITS-1:0] paddr,
  input  wire logic [PDATA_BITS-1:0] pwdata,
  output logic      [PDATA_BITS-1:0] prdata,
  output logic                       pready
);

  localparam int AW = $clog2(BASIS_DEPTH);

  cfg_t                  cfg;
  res_t                  walk_res;
  res_t                  res_q;
  logic                  out_valid_q;
  logic                  busy;
  logic                  done;
  logic                  take;
  logic                  accept;
  logic                  we;
  logic [AW-1:0]         raddr_a, raddr_b;
  logic [VALUE_BITS-1:0] rdata_a, rdata_b;

  // Input handshake and table write
  assign item_in_i.ready = !busy;
  assign accept          = item_in_i.valid && !busy;
  assign we              = accept && (item_in_i.command == CMD_LOAD)
                           && (32'(item_in_i.entry_index) < BASIS_DEPTH);

  bbps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bbps_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (BASIS_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (AW'(item_in_i.entry_index)),
    .wdata_i   (VALUE_BITS'(item_in_i.operand_value)),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  bbps_walk #(
    .BASIS_DEPTH (BASIS_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .start_i   (accept && (item_in_i.command == CMD_QUERY)),
    .val_i     (VALUE_BITS'(item_in_i.operand_value)),
    .take_i    (take),
    .busy_o    (busy),
    .done_o    (done),
    .res_o     (walk_res),
    .raddr_a_o (raddr_a),
    .raddr_b_o (raddr_b),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b)
  );

  // Output register
  assign take = done && (!out_valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= walk_res;
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.pair_found  = res_q.pair_found;
  assign result_o.first_code  = res_q.first_code;
  assign result_o.second_code = res_q.second_code;

endmodule

`default_nettype wire

// ===== design/bbps_chk.sv =====
`default_nettype none

`include "best_basis_pair_search_core_assert.svh"

module bbps_chk import bbps_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_i,
  input wire logic [CMD_BITS-1:0]  in_command_i,
  input wire logic                 out_valid_i,
  input wire logic                 out_ready_i,
  input wire logic                 out_found_i,
  input wire logic [CODE_BITS-1:0] out_first_i,
  input wire logic [CODE_BITS-1:0] out_second_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A stalled result keeps its fields
  `BBPS_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_found_i) && $stable(out_first_i) && $stable(out_second_i))

  // No pair means zero codes
  `BBPS_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, out_valid_i && !out_found_i, out_first_i == '0 && out_second_i == '0)

  // A query keeps the input closed while it runs
  `BBPS_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_acc && in_command_i == CMD_QUERY, !in_ready_i)

  // A load never raises a result on its own
  `BBPS_ASSERT_NEXT(a_load_quiet, clk_i, rst_ni, in_acc && in_command_i == CMD_LOAD && !out_valid_i, !out_valid_i)

endmodule

bind best_basis_pair_search_core bbps_chk u_bbps_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_in_i.valid),
  .in_ready_i   (item_in_i.ready),
  .in_command_i (item_in_i.command),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_found_i  (result_o.pair_found),
  .out_first_i  (result_o.first_code),
  .out_second_i (result_o.second_code)
);

`default_nettype wire
